// ----- sv/cas_pkg.sv -----
package cas_pkg;

    // Opcodes handled by the execute unit
    localparam logic [7:0] OP_LXI_B = 8'h01;
    localparam logic [7:0] OP_SUB_B = 8'h90;
    localparam logic [7:0] OP_ADI   = 8'hC6;
    localparam logic [7:0] OP_ACI   = 8'hCE;

    // ADD r / ADC r groups: upper five opcode bits, register field in [2:0]
    localparam logic [4:0] OP_ADD_GRP = 5'b10000;
    localparam logic [4:0] OP_ADC_GRP = 5'b10001;

    // Source register field
    localparam logic [2:0] SRC_B = 3'd0;
    localparam logic [2:0] SRC_C = 3'd1;
    localparam logic [2:0] SRC_D = 3'd2;
    localparam logic [2:0] SRC_E = 3'd3;
    localparam logic [2:0] SRC_H = 3'd4;
    localparam logic [2:0] SRC_L = 3'd5;
    localparam logic [2:0] SRC_M = 3'd6;
    localparam logic [2:0] SRC_A = 3'd7;

    // Instruction lengths
    localparam logic [1:0] LEN_1 = 2'd1;
    localparam logic [1:0] LEN_2 = 2'd2;
    localparam logic [1:0] LEN_3 = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_D = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_E = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_H = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_L = 3'd3;

    typedef struct packed {
        logic [7:0]  acc;
        logic [7:0]  b;
        logic [7:0]  c;
        logic        z;
        logic        s;
        logic        p;
        logic        cy;
        logic [15:0] pc;
    } t_arch_state;

    typedef struct packed {
        logic [7:0] d;
        logic [7:0] e;
        logic [7:0] h;
        logic [7:0] l;
    } t_cfg_regs;

endpackage

// ----- sv/cas_if.sv -----
interface cas_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] opcode_byte;
    logic [7:0] immediate_low;
    logic [7:0] immediate_high;
    logic [7:0] memory_operand;

    modport source (
        output valid, opcode_byte, immediate_low, immediate_high, memory_operand,
        input  ready
    );
    modport sink (
        input  valid, opcode_byte, immediate_low, immediate_high, memory_operand,
        output ready
    );
endinterface

interface cas_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  accumulator;
    logic [7:0]  reg_b_out;
    logic [7:0]  reg_c_out;
    logic        zero_flag;
    logic        sign_flag;
    logic        parity_flag;
    logic        carry_flag;
    logic [15:0] next_pc;
    logic [15:0] operand_address;

    modport source (
        output valid, accumulator, reg_b_out, reg_c_out, zero_flag, sign_flag,
               parity_flag, carry_flag, next_pc, operand_address,
        input  ready
    );
    modport sink (
        input  valid, accumulator, reg_b_out, reg_c_out, zero_flag, sign_flag,
               parity_flag, carry_flag, next_pc, operand_address,
        output ready
    );
endinterface

// ----- sv/cas_alu.sv -----
module cas_alu
    import cas_pkg::*;
(
    input  t_arch_state i_st,
    input  t_cfg_regs   i_cfg,
    input  logic [7:0]  i_opcode,
    input  logic [7:0]  i_imm_lo,
    input  logic [7:0]  i_imm_hi,
    input  logic [7:0]  i_mem,
    output t_arch_state o_st
);

    logic [7:0] src;
    logic [7:0] opnd;
    logic       cin;
    logic       is_arith;
    logic       is_sub;
    logic [1:0] len;
    logic [8:0] res;

    always_comb begin
        case (i_opcode[2:0])
            SRC_B:   src = i_st.b;
            SRC_C:   src = i_st.c;
            SRC_D:   src = i_cfg.d;
            SRC_E:   src = i_cfg.e;
            SRC_H:   src = i_cfg.h;
            SRC_L:   src = i_cfg.l;
            SRC_M:   src = i_mem;
            SRC_A:   src = i_st.acc;
            default: src = i_st.acc;
        endcase
    end

    // Decode
    always_comb begin
        opnd     = src;
        cin      = 1'b0;
        is_arith = 1'b0;
        is_sub   = 1'b0;
        len      = LEN_1;
        if (i_opcode == OP_LXI_B) begin
            len = LEN_3;
        end else if (i_opcode[7:3] == OP_ADD_GRP) begin
            is_arith = 1'b1;
        end else if (i_opcode[7:3] == OP_ADC_GRP) begin
            is_arith = 1'b1;
            cin      = i_st.cy;
        end else if (i_opcode == OP_SUB_B) begin
            is_arith = 1'b1;
            is_sub   = 1'b1;
            opnd     = i_st.b;
        end else if (i_opcode == OP_ADI) begin
            is_arith = 1'b1;
            opnd     = i_imm_lo;
            len      = LEN_2;
        end else if (i_opcode == OP_ACI) begin
            is_arith = 1'b1;
            opnd     = i_imm_lo;
            cin      = i_st.cy;
            len      = LEN_2;
        end
    end

    // 9-bit add or subtract; bit 8 is carry or borrow
    always_comb begin
        if (is_sub) begin
            res = {1'b0, i_st.acc} - {1'b0, opnd};
        end else begin
            res = {1'b0, i_st.acc} + {1'b0, opnd} + {8'd0, cin};
        end
    end

    always_comb begin
        o_st    = i_st;
        o_st.pc = i_st.pc + {14'd0, len};
        if (i_opcode == OP_LXI_B) begin
            o_st.b = i_imm_hi;
            o_st.c = i_imm_lo;
        end
        if (is_arith) begin
            o_st.acc = res[7:0];
            o_st.z   = (res[7:0] == 8'd0);
            o_st.s   = res[7];
            o_st.p   = ~^res[7:0];
            o_st.cy  = res[8];
        end
    end

endmodule

// ----- sv/cpu8080_add_sub_execute_top.sv -----
// Channel  | Dir | Modport | Payload
// ---------+-----+---------+---------------------------------------------------
// i_in     | in  | sink    | opcode_byte, immediate_low/high, memory_operand
// o_out    | out | source  | A, B, C, Z/S/P/CY, next_pc, operand_address
// cfg      | in  | -       | i_cfg_we, i_cfg_idx, i_cfg_data (D, E, H, L)
//
// One transaction per cycle sustained while o_out.ready is high; each instruction
// goes through the input register, then the ALU into the architectural/result register.
// The architectural registers double as the result register, so the next
// instruction sees the previous result without any forwarding.
// Synchronous active-low reset clears A, B, C, flags, PC and D/E/H/L.
// An output stall backs up into the input register, then drops i_in.ready.
module cpu8080_add_sub_execute_top
    import cas_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]           i_cfg_data,
    cas_in_if.sink               i_in,
    cas_out_if.source            o_out
);

    // Configuration registers
    t_cfg_regs r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_REG_D: r_cfg.d <= i_cfg_data;
                CFG_REG_E: r_cfg.e <= i_cfg_data;
                CFG_REG_H: r_cfg.h <= i_cfg_data;
                CFG_REG_L: r_cfg.l <= i_cfg_data;
                default:   r_cfg   <= r_cfg;
            endcase
        end
    end

    // Input register
    logic       r_in_valid;
    logic [7:0] r_op;
    logic [7:0] r_imm_lo;
    logic [7:0] r_imm_hi;
    logic [7:0] r_mem;

    // Result / architectural registers
    logic        r_out_valid;
    t_arch_state r_st;
    t_arch_state n_st;
    logic [15:0] r_addr;

    logic advance;
    logic in_take;

    // Item moves from the input register into the result register
    assign advance = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign in_take = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op     <= i_in.opcode_byte;
            r_imm_lo <= i_in.immediate_low;
            r_imm_hi <= i_in.immediate_high;
            r_mem    <= i_in.memory_operand;
        end
    end

    cas_alu u_alu (
        .i_st     (r_st),
        .i_cfg    (r_cfg),
        .i_opcode (r_op),
        .i_imm_lo (r_imm_lo),
        .i_imm_hi (r_imm_hi),
        .i_mem    (r_mem),
        .o_st     (n_st)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_st        <= '0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_st        <= n_st;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // H:L sampled with the instruction
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_addr <= {r_cfg.h, r_cfg.l};
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.accumulator     = r_st.acc;
    assign o_out.reg_b_out       = r_st.b;
    assign o_out.reg_c_out       = r_st.c;
    assign o_out.zero_flag       = r_st.z;
    assign o_out.sign_flag       = r_st.s;
    assign o_out.parity_flag     = r_st.p;
    assign o_out.carry_flag      = r_st.cy;
    assign o_out.next_pc         = r_st.pc;
    assign o_out.operand_address = r_addr;

    // Assertions
    a_advance_gives_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out.valid
    ) else $error("result not presented after advance");

    a_take_fills_input: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_in_valid
    ) else $error("accepted transaction lost from input register");

    a_stall_holds_state: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_st)
    ) else $error("architectural state changed without an instruction");

    a_addr_tracks_hl: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out.operand_address == {$past(r_cfg.h), $past(r_cfg.l)}
    ) else $error("operand address does not match H:L");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

// Execute-unit testbench for the 8080 ADD/ADC/SUB subset.
// Runs a directed pass over every opcode class and operand extreme, then random
// instruction streams under several D/E/H/L settings. A back-to-back LXI B run
// and a random tail close the stream. A mirror of A, B, C, flags and PC predicts
// each result, and every output transaction is compared field by field
// against the oldest prediction.
module testbench;
    import cas_pkg::*;

    localparam int unsigned IDLE_LIMIT       = 1000;  // cycles without any transaction
    localparam int unsigned SETTLE_CYCLES    = 4;     // pipeline is two deep
    localparam int unsigned DRAIN_CYCLES     = 6;
    localparam int unsigned LONG_HOLD_AT     = 150;   // accepted inputs before the long stall
    localparam int unsigned LONG_HOLD_CYCLES = 80;
    localparam int unsigned MAX_REPORTS      = 10;
    localparam int unsigned PHASE_ITEMS      = 95;
    localparam int unsigned TAIL_ITEMS       = 60;
    // Back-to-back LXI B run near the end
    localparam int unsigned LXI_RUN_ITEMS    = 40;

    localparam logic [7:0] OP_NOP = 8'h00;
    localparam logic [7:0] OP_JMP = 8'hC3;
    // Indexes above L select no register and must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = CFG_REG_L + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = '1;

    typedef struct packed {
        logic [7:0] opcode;
        logic [7:0] imm_lo;
        logic [7:0] imm_hi;
        logic [7:0] mem;
    } t_instr;

    typedef struct packed {
        t_arch_state arch;
        logic [15:0] hl;
    } t_exec_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [7:0]           i_cfg_data;

    cas_in_if  in_if ();
    cas_out_if out_if ();

    cpu8080_add_sub_execute_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // Mirror of the architectural state and of the D/E/H/L registers
    t_arch_state  arch_model   = '0;
    t_cfg_regs    cfg_model    = '0;

    t_instr       instr_q[$];        // instructions waiting to be offered
    t_exec_result arch_expect_q[$];  // predicted results, oldest first

    int unsigned  queued_cnt   = 0;
    int unsigned  accepted_cnt = 0;
    int unsigned  retired_cnt  = 0;
    int unsigned  fail_cnt     = 0;
    int unsigned  idle_cycles  = 0;
    int unsigned  send_gap     = 0;
    int unsigned  stall_gap    = 0;
    int unsigned  hold_left    = 0;
    bit           idle_on      = 1'b1;
    bit           long_hold_done = 1'b0;
    logic         in_fire      = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [7:0] source_operand(logic [2:0] sel, logic [7:0] mem);
        case (sel)
            SRC_B:   return arch_model.b;
            SRC_C:   return arch_model.c;
            SRC_D:   return cfg_model.d;
            SRC_E:   return cfg_model.e;
            SRC_H:   return cfg_model.h;
            SRC_L:   return cfg_model.l;
            SRC_M:   return mem;
            default: return arch_model.acc;
        endcase
    endfunction

    // Advances the mirror by one instruction and returns the state it leaves
    function automatic t_exec_result execute_instr(t_instr ins);
        logic [8:0]   sum;
        logic [1:0]   len;
        logic         alu;
        t_exec_result res;
        sum = '0;
        len = LEN_1;
        alu = 1'b1;
        if (ins.opcode == OP_LXI_B) begin
            arch_model.b = ins.imm_hi;
            arch_model.c = ins.imm_lo;
            len = LEN_3;
            alu = 1'b0;
        end else if (ins.opcode[7:3] == OP_ADD_GRP) begin
            sum = {1'b0, arch_model.acc} + {1'b0, source_operand(ins.opcode[2:0], ins.mem)};
        end else if (ins.opcode[7:3] == OP_ADC_GRP) begin
            sum = {1'b0, arch_model.acc} + {1'b0, source_operand(ins.opcode[2:0], ins.mem)}
                + 9'(arch_model.cy);
        end else if (ins.opcode == OP_SUB_B) begin
            // Ninth bit of the difference is the borrow
            sum = {1'b0, arch_model.acc} - {1'b0, arch_model.b};
        end else if (ins.opcode == OP_ADI) begin
            sum = {1'b0, arch_model.acc} + {1'b0, ins.imm_lo};
            len = LEN_2;
        end else if (ins.opcode == OP_ACI) begin
            sum = {1'b0, arch_model.acc} + {1'b0, ins.imm_lo} + 9'(arch_model.cy);
            len = LEN_2;
        end else begin
            alu = 1'b0;  // NOP, JMP and everything unhandled only move the PC
        end
        if (alu) begin
            arch_model.acc = sum[7:0];
            arch_model.z   = (sum[7:0] == 8'h00);
            arch_model.s   = sum[7];
            arch_model.p   = ~^sum[7:0];
            arch_model.cy  = sum[8];
        end
        arch_model.pc = arch_model.pc + 16'(len);
        res.arch = arch_model;
        res.hl   = {cfg_model.h, cfg_model.l};
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_instr(t_instr ins);
        instr_q.push_back(ins);
        queued_cnt++;
    endfunction

    // Mostly handled opcodes so flags and carry chains get exercised;
    // the rest covers the whole opcode space.
    function automatic t_instr rand_instr();
        t_instr      ins;
        int unsigned pick;
        ins.imm_lo = 8'($urandom);
        ins.imm_hi = 8'($urandom);
        ins.mem    = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 28)      ins.opcode = {OP_ADD_GRP, 3'($urandom)};
        else if (pick < 54) ins.opcode = {OP_ADC_GRP, 3'($urandom)};
        else if (pick < 64) ins.opcode = OP_SUB_B;
        else if (pick < 74) ins.opcode = OP_ADI;
        else if (pick < 84) ins.opcode = OP_ACI;
        else if (pick < 91) ins.opcode = OP_LXI_B;
        else                ins.opcode = 8'($urandom);
        return ins;
    endfunction

    // Every queued instruction accepted, every result back, pipeline settled
    task automatic wait_drained();
        while (accepted_cnt != queued_cnt || arch_expect_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Writes D, E, H, L and then one spare index that has to be ignored
    task automatic load_regs(t_cfg_regs regs);
        logic [CFG_IDX_W-1:0] idx [5];
        logic [7:0]           val [5];
        wait_drained();
        idx = '{CFG_REG_D, CFG_REG_E, CFG_REG_H, CFG_REG_L,
                CFG_IDX_W'($urandom_range(CFG_SPARE_LAST, CFG_SPARE_FIRST))};
        val = '{regs.d, regs.e, regs.h, regs.l, 8'($urandom)};
        foreach (idx[k]) begin
            @(negedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx[k];
            i_cfg_data <= val[k];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_model = regs;
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS)
                $display("result %0d: %s expected %h, got %h", retired_cnt, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Input driver: one transaction offered at a time, held until accepted
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_in
        t_instr ins;
        if (i_rst_n && (!in_if.valid || in_fire)) begin
            if (send_gap != 0) begin
                send_gap--;
                in_if.valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 11) == 0) begin
                send_gap = $urandom_range(0, 16);
                in_if.valid <= 1'b0;
            end else if (instr_q.size() != 0) begin
                ins = instr_q.pop_front();
                in_if.valid          <= 1'b1;
                in_if.opcode_byte    <= ins.opcode;
                in_if.immediate_low  <= ins.imm_lo;
                in_if.immediate_high <= ins.imm_hi;
                in_if.memory_operand <= ins.mem;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output sink: random stalls, plus one long hold that backs the block up
    // until it refuses input
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_out
        if (i_rst_n) begin
            if (!long_hold_done && accepted_cnt >= LONG_HOLD_AT) begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (stall_gap != 0) begin
                stall_gap--;
                out_if.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                stall_gap = $urandom_range(0, 16);
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on input transactions, checks output transactions,
    // and stops a hung run
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_exec_result want;
        if (out_if.valid && out_if.ready) begin
            if (arch_expect_q.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= MAX_REPORTS)
                    $display("result %0d: no result was due (A %h, PC %h)",
                             retired_cnt, out_if.accumulator, out_if.next_pc);
            end else begin
                want = arch_expect_q.pop_front();
                check_field("A",   16'(want.arch.acc), 16'(out_if.accumulator));
                check_field("B",   16'(want.arch.b),   16'(out_if.reg_b_out));
                check_field("C",   16'(want.arch.c),   16'(out_if.reg_c_out));
                check_field("Z",   16'(want.arch.z),   16'(out_if.zero_flag));
                check_field("S",   16'(want.arch.s),   16'(out_if.sign_flag));
                check_field("P",   16'(want.arch.p),   16'(out_if.parity_flag));
                check_field("CY",  16'(want.arch.cy),  16'(out_if.carry_flag));
                check_field("PC",  want.arch.pc,       out_if.next_pc);
                check_field("H:L", want.hl,            out_if.operand_address);
            end
            retired_cnt++;
        end
        if (in_if.valid && in_if.ready) begin
            arch_expect_q.push_back(execute_instr(t_instr'{in_if.opcode_byte,
                in_if.immediate_low, in_if.immediate_high, in_if.memory_operand}));
            accepted_cnt++;
        end
        in_fire <= in_if.valid && in_if.ready;

        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        t_cfg_regs regs;
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = '0;
        i_cfg_data           = '0;
        in_if.valid          = 1'b0;
        in_if.opcode_byte    = '0;
        in_if.immediate_low  = '0;
        in_if.immediate_high = '0;
        in_if.memory_operand = '0;
        out_if.ready         = 1'b0;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: each opcode class, extreme operands, unhandled opcodes
        load_regs(t_cfg_regs'{8'hFF, 8'h01, 8'h80, 8'h7F});
        queue_instr(t_instr'{OP_NOP, 8'($urandom), 8'($urandom), 8'($urandom)});
        queue_instr(t_instr'{OP_LXI_B, 8'hFF, 8'hFF, 8'($urandom)});
        for (int s = 0; s < 8; s++)
            queue_instr(t_instr'{{OP_ADD_GRP, 3'(s)}, 8'($urandom), 8'($urandom), 8'hFF});
        queue_instr(t_instr'{OP_ACI, 8'hFF, 8'($urandom), 8'($urandom)});
        for (int s = 0; s < 8; s++)
            queue_instr(t_instr'{{OP_ADC_GRP, 3'(s)}, 8'($urandom), 8'($urandom), 8'h00});
        queue_instr(t_instr'{OP_SUB_B, 8'($urandom), 8'($urandom), 8'($urandom)});
        queue_instr(t_instr'{OP_LXI_B, 8'h00, 8'h00, 8'($urandom)});
        queue_instr(t_instr'{OP_SUB_B, 8'($urandom), 8'($urandom), 8'($urandom)});
        queue_instr(t_instr'{OP_ADI, 8'h00, 8'($urandom), 8'($urandom)});
        queue_instr(t_instr'{OP_ADI, 8'hFF, 8'($urandom), 8'($urandom)});
        queue_instr(t_instr'{OP_JMP, 8'($urandom), 8'($urandom), 8'($urandom)});
        queue_instr(t_instr'{8'hFF, 8'($urandom), 8'($urandom), 8'($urandom)});

        // Random streams: registers all clear, all set, then random;
        // one phase runs without idling
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0:       regs = '0;
                1:       regs = '1;
                default: regs = t_cfg_regs'($urandom);
            endcase
            load_regs(regs);
            idle_on = (ph != 2);
            repeat (PHASE_ITEMS) queue_instr(rand_instr());
        end

        // Back-to-back LXI B run, then a random tail; idling off
        // from here to the end
        load_regs(t_cfg_regs'($urandom));
        idle_on = 1'b0;
        repeat (LXI_RUN_ITEMS)
            queue_instr(t_instr'{OP_LXI_B, 8'($urandom), 8'($urandom), 8'($urandom)});
        repeat (TAIL_ITEMS) queue_instr(rand_instr());

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_cnt == 0 && arch_expect_q.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/cas_pkg.sv
sv/cas_if.sv
sv/cas_alu.sv
sv/cpu8080_add_sub_execute_top.sv
verif/testbench.sv
